// ===== sv/pdce_pkg.sv =====
// ----------------------------------------------------------------------------
// pdce_pkg
// Shared constants and types for the pairwise distance consistency error core.
// ----------------------------------------------------------------------------
package pdce_pkg;
    localparam int MAX_PAIRS  = 256;
    localparam int COORD_BITS = 12;
    localparam int IDX_BITS   = $clog2(MAX_PAIRS);
    localparam int CNT_BITS   = $clog2(MAX_PAIRS + 1);
    // Squared distance scaled by 2^8: two squares plus one bit, then eight.
    localparam int SQ_BITS    = 2 * COORD_BITS + 1 + 8;
    localparam int RT_BITS    = (SQ_BITS + 1) / 2;
    localparam int SUM_BITS   = RT_BITS + 2 * IDX_BITS + 2;
    localparam int DIV_BITS   = 2 * CNT_BITS;
    localparam int MEAN_BITS  = 17;
    localparam logic [MEAN_BITS-1:0] MEAN_MAX = '1;

    typedef struct packed {
        logic [COORD_BITS-1:0] dy;
        logic [COORD_BITS-1:0] dx;
        logic [COORD_BITS-1:0] cy;
        logic [COORD_BITS-1:0] cx;
    } pair_t;
endpackage

// ===== sv/pdce_dist.sv =====
// ----------------------------------------------------------------------------
// pdce_dist
// Bit-serial squared distance and integer square root, one root bit per cycle
// after a serial square.
// ----------------------------------------------------------------------------
module pdce_dist
    import pdce_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [COORD_BITS-1:0] x0,
    input  logic [COORD_BITS-1:0] y0,
    input  logic [COORD_BITS-1:0] x1,
    input  logic [COORD_BITS-1:0] y1,
    output logic                  done,
    output logic [RT_BITS-1:0]    root
);
    typedef enum logic [1:0] {S_IDLE, S_SQX, S_SQY, S_ROOT} state_t;
    localparam int SC_BITS  = $clog2(RT_BITS + 1);
    // The radicand is held in an even number of bits so that the root
    // digits pair up from the least significant end.
    localparam int RAD_BITS = 2 * RT_BITS;

    state_t               state_reg;
    logic [COORD_BITS-1:0] ay_reg, mul_reg;
    logic [RAD_BITS-1:0]  mcand_reg;
    logic [RAD_BITS-1:0]  acc_reg;
    logic [SQ_BITS-1:0]   rem_reg;
    logic [RT_BITS-1:0]   res_reg;
    logic [SC_BITS-1:0]   step_reg;
    logic                 done_reg;

    logic [COORD_BITS-1:0] adx, ady;
    logic [SQ_BITS+1:0]   trial;
    logic [SQ_BITS+1:0]   rem_sh;

    assign adx = (x0 > x1) ? x0 - x1 : x1 - x0;
    assign ady = (y0 > y1) ? y0 - y1 : y1 - y0;

    // Restoring root: bring down two bits of the radicand per cycle.
    assign rem_sh = {rem_reg, acc_reg[RAD_BITS-1 -: 2]};
    assign trial  = (SQ_BITS + 2)'({res_reg, 2'b01});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE: begin
                    if (start) begin
                        ay_reg    <= ady;
                        mul_reg   <= adx;
                        mcand_reg <= RAD_BITS'(adx) << 8;
                        acc_reg   <= '0;
                        step_reg  <= '0;
                        state_reg <= S_SQX;
                    end
                end
                // Shift-add square, one multiplier bit per cycle from the bottom.
                S_SQX, S_SQY: begin
                    acc_reg   <= acc_reg + (mul_reg[0] ? mcand_reg : '0);
                    mul_reg   <= mul_reg >> 1;
                    mcand_reg <= mcand_reg << 1;
                    step_reg  <= step_reg + 1'b1;
                    if (step_reg == SC_BITS'(COORD_BITS - 1)) begin
                        step_reg <= '0;
                        if (state_reg == S_SQX) begin
                            mul_reg   <= ay_reg;
                            mcand_reg <= RAD_BITS'(ay_reg) << 8;
                            state_reg <= S_SQY;
                        end else begin
                            rem_reg   <= '0;
                            res_reg   <= '0;
                            state_reg <= S_ROOT;
                        end
                    end
                end
                S_ROOT: begin
                    acc_reg  <= acc_reg << 2;
                    step_reg <= step_reg + 1'b1;
                    if (rem_sh >= trial) begin
                        rem_reg <= SQ_BITS'(rem_sh - trial);
                        res_reg <= {res_reg[RT_BITS-2:0], 1'b1};
                    end else begin
                        rem_reg <= SQ_BITS'(rem_sh);
                        res_reg <= {res_reg[RT_BITS-2:0], 1'b0};
                    end
                    if (step_reg == SC_BITS'(RT_BITS - 1)) begin
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign done = done_reg;
    assign root = res_reg;
endmodule

// ===== sv/pdce_div.sv =====
// ----------------------------------------------------------------------------
// pdce_div
// Restoring divider, one quotient bit per cycle, with saturation.
// ----------------------------------------------------------------------------
module pdce_div
    import pdce_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [SUM_BITS-1:0]   dividend,
    input  logic [DIV_BITS-1:0]   divisor,
    output logic                  done,
    output logic [MEAN_BITS-1:0]  quotient
);
    localparam int QC_BITS = $clog2(SUM_BITS + 1);

    logic                busy_reg, done_reg;
    logic [SUM_BITS-1:0] num_reg, quo_reg;
    logic [DIV_BITS:0]   rem_reg;
    logic [DIV_BITS-1:0] den_reg;
    logic [QC_BITS-1:0]  cnt_reg;
    logic [DIV_BITS:0]   rem_sh;

    assign rem_sh = {rem_reg[DIV_BITS-1:0], num_reg[SUM_BITS-1]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start && !busy_reg) begin
                busy_reg <= 1'b1;
                num_reg  <= dividend;
                den_reg  <= divisor;
                rem_reg  <= '0;
                quo_reg  <= '0;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                num_reg <= num_reg << 1;
                cnt_reg <= cnt_reg + 1'b1;
                if (rem_sh >= {1'b0, den_reg}) begin
                    rem_reg <= rem_sh - {1'b0, den_reg};
                    quo_reg <= {quo_reg[SUM_BITS-2:0], 1'b1};
                end else begin
                    rem_reg <= rem_sh;
                    quo_reg <= {quo_reg[SUM_BITS-2:0], 1'b0};
                end
                if (cnt_reg == QC_BITS'(SUM_BITS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = (quo_reg[SUM_BITS-1:MEAN_BITS] != '0) ? MEAN_MAX
                                                            : quo_reg[MEAN_BITS-1:0];
endmodule

// ===== sv/pairwise_distance_consistency_error_core.sv =====
// ----------------------------------------------------------------------------
// pairwise_distance_consistency_error_core
// Loads keypoint pairs and reports the mean pairwise distance discrepancy.
// ----------------------------------------------------------------------------
// Pairs load at one item per cycle into a 256-entry store. The item marked
// tlast starts the pass over all n*(n-1) ordered pairs: each pair reads two
// store entries in turn on the single read port and then runs both distances
// in two bit-serial square/root units side by side. A final divide by n*(n-1)
// gives the mean. The input is not ready during the pass or while a result
// waits in the output register.
module pairwise_distance_consistency_error_core
    import pdce_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata: camera_x[11:0], camera_y[23:12], dataset_x[35:24], dataset_y[47:36]
    input  logic [47:0] s_tdata,
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    // tdata: mean_error[16:0], too_few_pairs[17], overflow_dropped[18], zeros
    output logic [23:0] m_tdata
);
    typedef enum logic [2:0] {
        S_LOAD, S_RDI, S_RDJ, S_START, S_WAIT, S_DIV, S_OUT
    } state_t;

    pair_t               mem [MAX_PAIRS];
    pair_t               rd_reg, pi_reg, pj_reg;
    state_t              state_reg;
    logic [CNT_BITS-1:0] count_reg;
    logic                drop_reg;
    logic [IDX_BITS-1:0] i_reg, j_reg;
    logic [SUM_BITS-1:0] sum_reg;
    logic [MEAN_BITS-1:0] mean_reg;
    logic                few_reg, ovf_reg;
    logic [IDX_BITS-1:0] rd_addr;

    logic                d_start, da_done, db_done, dv_start, dv_done;
    logic [RT_BITS-1:0]  ra, rb;
    logic [MEAN_BITS-1:0] quo;
    logic [DIV_BITS-1:0] pairs_cnt;
    logic                s_acc;
    pair_t               in_pair;
    logic [IDX_BITS-1:0] last_idx;

    assign in_pair  = s_tdata;
    assign s_tready = (state_reg == S_LOAD);
    assign s_acc    = s_tvalid && s_tready;
    assign last_idx = IDX_BITS'(count_reg - 1'b1);
    assign pairs_cnt = DIV_BITS'(count_reg) * DIV_BITS'(count_reg - 1'b1);
    assign rd_addr  = (state_reg == S_RDI) ? i_reg : j_reg;

    // Store write and registered read.
    always_ff @(posedge aclk) begin
        if (s_acc && count_reg != CNT_BITS'(MAX_PAIRS))
            mem[count_reg[IDX_BITS-1:0]] <= in_pair;
        rd_reg <= mem[rd_addr];
    end

    // Sequencer over ordered pairs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_LOAD;
            count_reg <= '0;
            drop_reg  <= 1'b0;
            m_tvalid  <= 1'b0;
        end else begin
            case (state_reg)
                S_LOAD: begin
                    if (s_acc) begin
                        logic [CNT_BITS-1:0] n;
                        n = count_reg;
                        if (count_reg != CNT_BITS'(MAX_PAIRS))
                            n = count_reg + 1'b1;
                        else
                            drop_reg <= 1'b1;
                        count_reg <= n;
                        if (s_tlast) begin
                            ovf_reg <= drop_reg || (count_reg == CNT_BITS'(MAX_PAIRS));
                            sum_reg <= '0;
                            i_reg   <= '0;
                            j_reg   <= IDX_BITS'(1);
                            if (n < CNT_BITS'(2)) begin
                                few_reg   <= 1'b1;
                                mean_reg  <= '0;
                                m_tvalid  <= 1'b1;
                                state_reg <= S_OUT;
                            end else begin
                                few_reg   <= 1'b0;
                                state_reg <= S_RDI;
                            end
                        end
                    end
                end
                S_RDI: state_reg <= S_RDJ;
                S_RDJ: begin
                    pi_reg    <= rd_reg;
                    state_reg <= S_START;
                end
                S_START: begin
                    pj_reg    <= rd_reg;
                    state_reg <= S_WAIT;
                end
                S_WAIT: begin
                    if (da_done) begin
                        sum_reg <= sum_reg + SUM_BITS'((ra > rb) ? ra - rb : rb - ra);
                        if (j_reg == last_idx) begin
                            if (i_reg == last_idx) begin
                                state_reg <= S_DIV;
                            end else begin
                                i_reg     <= i_reg + 1'b1;
                                j_reg     <= (i_reg + 1'b1 == '0) ? IDX_BITS'(1) : '0;
                                state_reg <= S_RDI;
                            end
                        end else if (j_reg + 1'b1 == i_reg) begin
                            if (i_reg == last_idx) state_reg <= S_DIV;
                            else begin
                                j_reg     <= j_reg + 2'd2;
                                state_reg <= S_RDI;
                            end
                        end else begin
                            j_reg     <= j_reg + 1'b1;
                            state_reg <= S_RDI;
                        end
                    end
                end
                S_DIV: begin
                    if (dv_done) begin
                        mean_reg  <= quo;
                        m_tvalid  <= 1'b1;
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (m_tready) begin
                        m_tvalid  <= 1'b0;
                        count_reg <= '0;
                        drop_reg  <= 1'b0;
                        state_reg <= S_LOAD;
                    end
                end
                default: state_reg <= S_LOAD;
            endcase
        end
    end

    // Pair units start once both entries are held.
    logic start_pend_reg, div_pend_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_pend_reg <= 1'b0;
            div_pend_reg   <= 1'b0;
        end else begin
            start_pend_reg <= (state_reg == S_START);
            div_pend_reg   <= (state_reg == S_WAIT) && da_done &&
                              (i_reg == last_idx) &&
                              (j_reg == last_idx || j_reg + 1'b1 == i_reg);
        end
    end
    assign d_start  = start_pend_reg;
    assign dv_start = div_pend_reg;

    pdce_dist u_dist_cam (
        .aclk(aclk), .aresetn(aresetn), .start(d_start),
        .x0(pi_reg.cx), .y0(pi_reg.cy), .x1(pj_reg.cx), .y1(pj_reg.cy),
        .done(da_done), .root(ra)
    );

    pdce_dist u_dist_set (
        .aclk(aclk), .aresetn(aresetn), .start(d_start),
        .x0(pi_reg.dx), .y0(pi_reg.dy), .x1(pj_reg.dx), .y1(pj_reg.dy),
        .done(db_done), .root(rb)
    );

    pdce_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(dv_start),
        .dividend(sum_reg), .divisor(pairs_cnt),
        .done(dv_done), .quotient(quo)
    );

    assign m_tdata = {5'b0, ovf_reg, few_reg, mean_reg};

    // Both distance units run in lockstep.
    a_lockstep: assert property (@(posedge aclk) disable iff (!aresetn)
        da_done == db_done) else $error("distance units out of step");
    // The store never holds more than its depth.
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_BITS'(MAX_PAIRS)) else $error("pair count overrun");
    // No input is taken while a result is pending.
    a_noload: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready) else $error("load during result");
    // A flagged short set reports zero.
    a_few: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && few_reg) |-> (mean_reg == '0)) else $error("short set nonzero");
endmodule

// ===== verif/pairwise_distance_consistency_error_core_test.sv =====
// ----------------------------------------------------------------------------
// pairwise_distance_consistency_error_core_test
// Self-checking testbench for the pairwise distance consistency error core.
// It drives sets of keypoint pairs from a directed table, at random and as one overfull set.
// Each result is checked against the report of a typed table row, else against an internal
// predictor of the mean pairwise distance discrepancy. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module pairwise_distance_consistency_error_core_test;
    import pdce_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // The limit is set well above the time that a full store takes in one pass.
    localparam int unsigned IDLE_LIMIT = 10_000_000;
    localparam int RANDOM_ITEMS = 900;

    typedef logic [COORD_BITS-1:0] coord_t;

    typedef struct {
        logic [MEAN_BITS-1:0] mean_error;
        logic                 too_few;
        logic                 dropped;
    } error_report_t;

    typedef struct {
        coord_t cx, cy, dx, dy;
        logic   last;
        logic   typed;
        error_report_t want;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;

    pairwise_distance_consistency_error_core u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #5 aclk = ~aclk;

    // Predictor state: the stored pairs, their count and the dropped flag.
    coord_t      pred_store [MAX_PAIRS][4];
    int unsigned pred_count = 0;
    logic        pred_dropped = 1'b0;

    error_report_t report_queue [$];
    int unsigned   error_count = 0;
    logic          item_taken = 1'b0;
    int unsigned   idle_cycles = 0;
    int unsigned   rx_wait = 0;
    logic          quiet_mode = 1'b0;

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r = 0;
        longint unsigned b = 64'h1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint unsigned dist_q4(coord_t x0, coord_t y0, coord_t x1, coord_t y1);
        longint unsigned ax = (x0 > x1) ? x0 - x1 : x1 - x0;
        longint unsigned ay = (y0 > y1) ? y0 - y1 : y1 - y0;
        return int_sqrt((ax * ax + ay * ay) << 8);
    endfunction

    // Load one pair into the predictor; returns 1 with the report when the set closes.
    function automatic bit predict_pair(coord_t cx, coord_t cy, coord_t dx, coord_t dy,
                                        logic last, output error_report_t rep);
        longint unsigned sum = 0;
        longint unsigned mean = 0;
        longint unsigned a, b;
        if (pred_count < MAX_PAIRS) begin
            pred_store[pred_count] = '{cx, cy, dx, dy};
            pred_count++;
        end else begin
            pred_dropped = 1'b1;
        end
        if (!last) return 0;
        if (pred_count >= 2) begin
            for (int i = 0; i < pred_count; i++)
                for (int j = 0; j < pred_count; j++) begin
                    if (i == j) continue;
                    a = dist_q4(pred_store[i][0], pred_store[i][1],
                                pred_store[j][0], pred_store[j][1]);
                    b = dist_q4(pred_store[i][2], pred_store[i][3],
                                pred_store[j][2], pred_store[j][3]);
                    sum += (a > b) ? a - b : b - a;
                end
            mean = sum / (longint'(pred_count) * (pred_count - 1));
            if (mean > MEAN_MAX) mean = MEAN_MAX;
        end
        rep.mean_error = mean[MEAN_BITS-1:0];
        rep.too_few    = (pred_count < 2);
        rep.dropped    = pred_dropped;
        pred_count   = 0;
        pred_dropped = 1'b0;
        return 1;
    endfunction

    // Present one item after a random gap and hold it until it is accepted.
    task automatic send_pair(coord_t cx, coord_t cy, coord_t dx, coord_t dy, logic last);
        int unsigned gap = quiet_mode ? 0 : $urandom_range(0, 6);
        repeat (gap) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {dy, dx, cy, cx};
        s_tlast  <= last;
        @(negedge aclk);
        while (!item_taken) @(negedge aclk);
    endtask

    task automatic load_pair(coord_t cx, coord_t cy, coord_t dx, coord_t dy, logic last,
                             logic typed, error_report_t want);
        error_report_t rep;
        if (predict_pair(cx, cy, dx, dy, last, rep))
            report_queue.insert(report_queue.size(), typed ? want : rep);
        send_pair(cx, cy, dx, dy, last);
    endtask

    function automatic coord_t rand_coord();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            default: return coord_t'($urandom());
        endcase
    endfunction

    // Accept monitor, result checker and watchdog, all on the rising edge.
    always @(posedge aclk) begin
        item_taken <= s_tvalid && s_tready;
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
        if (m_tvalid && m_tready) begin
            rx_wait = quiet_mode ? 0 : $urandom_range(0, 6);
            if (report_queue.size() == 0) begin
                $display("%0t: result %h with no report expected", $time, m_tdata);
                error_count++;
            end else begin
                error_report_t w;
                w = report_queue.pop_front();
                if (m_tdata !== {5'b0, w.dropped, w.too_few, w.mean_error}) begin
                    $display("%0t: expected mean %0d few %0b drop %0b, got mean %0d few %0b drop %0b pad %h",
                             $time, w.mean_error, w.too_few, w.dropped,
                             m_tdata[16:0], m_tdata[17], m_tdata[18], m_tdata[23:19]);
                    error_count++;
                end
            end
        end
    end

    // Result side stall.
    always @(negedge aclk) begin
        if (rx_wait > 0) begin
            m_tready <= 1'b0;
            rx_wait--;
        end else begin
            m_tready <= 1'b1;
        end
    end

    stim_row_t directed [] = '{
        '{12'd0,    12'd0,    12'd0,    12'd0,    1'b1, 1'b1, '{17'd0, 1'b1, 1'b0}},
        '{12'hFFF,  12'hFFF,  12'hFFF,  12'hFFF,  1'b1, 1'b1, '{17'd0, 1'b1, 1'b0}},
        '{12'd0,    12'd0,    12'd0,    12'd0,    1'b0, 1'b0, '{17'd0, 1'b0, 1'b0}},
        '{12'hFFF,  12'hFFF,  12'hFFF,  12'hFFF,  1'b1, 1'b1, '{17'd0, 1'b0, 1'b0}},
        '{12'd0,    12'd0,    12'd0,    12'd0,    1'b0, 1'b0, '{17'd0, 1'b0, 1'b0}},
        '{12'hFFF,  12'hFFF,  12'd0,    12'd0,    1'b1, 1'b0, '{17'd0, 1'b0, 1'b0}},
        '{12'hFFF,  12'd0,    12'd0,    12'hFFF,  1'b0, 1'b0, '{17'd0, 1'b0, 1'b0}},
        '{12'd0,    12'hFFF,  12'hFFF,  12'd0,    1'b0, 1'b0, '{17'd0, 1'b0, 1'b0}},
        '{12'd1234, 12'd2222, 12'd3333, 12'd444,  1'b1, 1'b0, '{17'd0, 1'b0, 1'b0}},
        '{12'hAAA,  12'h555,  12'h555,  12'hAAA,  1'b0, 1'b0, '{17'd0, 1'b0, 1'b0}},
        '{12'h555,  12'hAAA,  12'hAAA,  12'h555,  1'b1, 1'b0, '{17'd0, 1'b0, 1'b0}},
        '{12'hA5A,  12'h5A5,  12'hFFF,  12'h000,  1'b1, 1'b1, '{17'd0, 1'b1, 1'b0}}
    };

    initial begin
        int unsigned sent;
        int unsigned set_size;
        error_report_t none;
        none = '{17'd0, 1'b0, 1'b0};
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed table.
        foreach (directed[k])
            load_pair(directed[k].cx, directed[k].cy, directed[k].dx, directed[k].dy,
                      directed[k].last, directed[k].typed, directed[k].want);

        // Random sets, mostly small, with an occasional larger one.
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 9) == 0) quiet_mode = ~quiet_mode;
            case ($urandom_range(0, 9))
                0: set_size = 1;
                1: set_size = $urandom_range(10, 20);
                default: set_size = $urandom_range(2, 6);
            endcase
            for (int p = 0; p < set_size; p++)
                load_pair(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                          p == set_size - 1, 1'b0, none);
            sent += set_size;
        end

        // One overfull set: the store fills and the extra pairs are dropped.
        quiet_mode = 1'b1;
        for (int p = 0; p < MAX_PAIRS + 2; p++)
            load_pair(coord_t'($urandom()), coord_t'($urandom()),
                      coord_t'($urandom()), coord_t'($urandom()),
                      p == MAX_PAIRS + 1, 1'b0, none);
        s_tvalid <= 1'b0;

        while (report_queue.size() != 0) @(negedge aclk);
        repeat (200) @(negedge aclk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
